[rtl/kscd_pkg.sv]
// kscd_pkg: types, scan code constants and character tables for the
// keyboard scan code decoder. No dependencies.
`default_nettype none

package kscd_pkg;

	// configuration register file
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_ARROW  = 3'd0,
		REG_RIGHT_ARROW = 3'd1,
		REG_UP_ARROW    = 3'd2,
		REG_DOWN_ARROW  = 3'd3,
		REG_EXT_DELETE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] left_arrow;
		logic [7:0] right_arrow;
		logic [7:0] up_arrow;
		logic [7:0] down_arrow;
		logic [7:0] ext_delete;
	} kscd_cfg_t;

	localparam logic [7:0] LEFT_ARROW_RST  = 8'd28;
	localparam logic [7:0] RIGHT_ARROW_RST = 8'd29;
	localparam logic [7:0] UP_ARROW_RST    = 8'd30;
	localparam logic [7:0] DOWN_ARROW_RST  = 8'd31;
	localparam logic [7:0] EXT_DELETE_RST  = 8'd127;

	// prefix tracking
	typedef enum logic [1:0] {
		PFX_IDLE    = 2'd0,
		PFX_E0      = 2'd1,
		PFX_E1      = 2'd2,
		PFX_E1_CTRL = 2'd3
	} prefix_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_SCROLL_UP   = 3'd1,
		EV_SCROLL_DOWN = 3'd2,
		EV_DIAG_UP     = 3'd3,
		EV_DIAG_DOWN   = 3'd4,
		EV_INTERRUPT   = 3'd5
	} event_t;

	// modifier bit positions
	localparam int MOD_LALT   = 0;
	localparam int MOD_RALT   = 1;
	localparam int MOD_LCTRL  = 2;
	localparam int MOD_RCTRL  = 3;
	localparam int MOD_LSHIFT = 4;
	localparam int MOD_RSHIFT = 5;

	// lock bit positions
	localparam int LOCK_NUM    = 0;
	localparam int LOCK_CAPS   = 1;
	localparam int LOCK_SCROLL = 2;

	typedef struct packed {
		prefix_t    prefix;
		logic [5:0] mods;
		logic [2:0] locks;
		logic [2:0] held;
	} kscd_state_t;

	typedef struct packed {
		logic [7:0] char_code;
		event_t     event_code;
	} kscd_result_t;

	// scan codes
	localparam logic [7:0] SC_E0           = 8'he0;
	localparam logic [7:0] SC_E1           = 8'he1;
	localparam logic [7:0] SC_ALT          = 8'h38;
	localparam logic [7:0] SC_CTRL         = 8'h1d;
	localparam logic [7:0] SC_LSHIFT       = 8'h2a;
	localparam logic [7:0] SC_RSHIFT       = 8'h36;
	localparam logic [7:0] SC_ALT_REL      = 8'hb8;
	localparam logic [7:0] SC_CTRL_REL     = 8'h9d;
	localparam logic [7:0] SC_LSHIFT_REL   = 8'haa;
	localparam logic [7:0] SC_RSHIFT_REL   = 8'hb6;
	localparam logic [7:0] SC_NUMLOCK      = 8'h45;
	localparam logic [7:0] SC_CAPSLOCK     = 8'h3a;
	localparam logic [7:0] SC_SCROLLLOCK   = 8'h46;
	localparam logic [7:0] SC_NUMLOCK_REL  = 8'hc5;
	localparam logic [7:0] SC_CAPS_REL     = 8'hba;
	localparam logic [7:0] SC_SCROLL_REL   = 8'hc6;
	localparam logic [7:0] SC_PAGE_UP      = 8'h49;
	localparam logic [7:0] SC_PAGE_DOWN    = 8'h51;
	localparam logic [7:0] SC_LEFT         = 8'h4b;
	localparam logic [7:0] SC_RIGHT        = 8'h4d;
	localparam logic [7:0] SC_UP           = 8'h48;
	localparam logic [7:0] SC_DOWN         = 8'h50;
	localparam logic [7:0] SC_DELETE       = 8'h53;
	localparam logic [7:0] SC_W            = 8'h11;
	localparam logic [7:0] SC_S            = 8'h1f;

	// first keypad code and end of the keypad area
	localparam logic [7:0] SC_KEYPAD_BASE  = 8'h45;
	localparam logic [7:0] TABLE_ENTRIES   = 8'd88;

	localparam logic [7:0] PAUSE_CHAR      = 8'h05;
	localparam logic [7:0] CH_LOWER_A      = 8'h61;
	localparam logic [7:0] CH_LOWER_Z      = 8'h7a;
	localparam logic [7:0] CH_LOWER_C      = 8'h63;
	localparam logic [7:0] CTRL_OFFSET     = 8'h60;
	localparam logic [7:0] CASE_OFFSET     = 8'h20;

	function automatic logic [7:0] plain_map(input logic [6:0] idx);
		logic [7:0] ch;
		case (idx)
			7'h01: ch = 8'h1b;
			7'h02: ch = 8'h31;
			7'h03: ch = 8'h32;
			7'h04: ch = 8'h33;
			7'h05: ch = 8'h34;
			7'h06: ch = 8'h35;
			7'h07: ch = 8'h36;
			7'h08: ch = 8'h37;
			7'h09: ch = 8'h38;
			7'h0a: ch = 8'h39;
			7'h0b: ch = 8'h30;
			7'h0c: ch = 8'h2d;
			7'h0d: ch = 8'h3d;
			7'h0e: ch = 8'h08;
			7'h0f: ch = 8'h09;
			7'h10: ch = 8'h71;
			7'h11: ch = 8'h77;
			7'h12: ch = 8'h65;
			7'h13: ch = 8'h72;
			7'h14: ch = 8'h74;
			7'h15: ch = 8'h79;
			7'h16: ch = 8'h75;
			7'h17: ch = 8'h69;
			7'h18: ch = 8'h6f;
			7'h19: ch = 8'h70;
			7'h1a: ch = 8'h5b;
			7'h1b: ch = 8'h5d;
			7'h1c: ch = 8'h0a;
			7'h1e: ch = 8'h61;
			7'h1f: ch = 8'h73;
			7'h20: ch = 8'h64;
			7'h21: ch = 8'h66;
			7'h22: ch = 8'h67;
			7'h23: ch = 8'h68;
			7'h24: ch = 8'h6a;
			7'h25: ch = 8'h6b;
			7'h26: ch = 8'h6c;
			7'h27: ch = 8'h3b;
			7'h28: ch = 8'h27;
			7'h29: ch = 8'h60;
			7'h2b: ch = 8'h5c;
			7'h2c: ch = 8'h7a;
			7'h2d: ch = 8'h78;
			7'h2e: ch = 8'h63;
			7'h2f: ch = 8'h76;
			7'h30: ch = 8'h62;
			7'h31: ch = 8'h6e;
			7'h32: ch = 8'h6d;
			7'h33: ch = 8'h2c;
			7'h34: ch = 8'h2e;
			7'h35: ch = 8'h2f;
			7'h37: ch = 8'h2a;
			7'h39: ch = 8'h20;
			7'h47: ch = 8'h37;
			7'h48: ch = 8'h38;
			7'h49: ch = 8'h39;
			7'h4a: ch = 8'h2d;
			7'h4b: ch = 8'h34;
			7'h4c: ch = 8'h35;
			7'h4d: ch = 8'h36;
			7'h4e: ch = 8'h2b;
			7'h4f: ch = 8'h31;
			7'h50: ch = 8'h32;
			7'h51: ch = 8'h33;
			7'h52: ch = 8'h30;
			7'h53: ch = 8'h2e;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] shift_map(input logic [6:0] idx);
		logic [7:0] ch;
		case (idx)
			7'h01: ch = 8'h1b;
			7'h02: ch = 8'h21;
			7'h03: ch = 8'h40;
			7'h04: ch = 8'h23;
			7'h05: ch = 8'h24;
			7'h06: ch = 8'h25;
			7'h07: ch = 8'h5e;
			7'h08: ch = 8'h26;
			7'h09: ch = 8'h2a;
			7'h0a: ch = 8'h28;
			7'h0b: ch = 8'h29;
			7'h0c: ch = 8'h5f;
			7'h0d: ch = 8'h2b;
			7'h0e: ch = 8'h08;
			7'h0f: ch = 8'h09;
			7'h10: ch = 8'h71;
			7'h11: ch = 8'h77;
			7'h12: ch = 8'h65;
			7'h13: ch = 8'h72;
			7'h14: ch = 8'h74;
			7'h15: ch = 8'h79;
			7'h16: ch = 8'h75;
			7'h17: ch = 8'h69;
			7'h18: ch = 8'h6f;
			7'h19: ch = 8'h70;
			7'h1a: ch = 8'h7b;
			7'h1b: ch = 8'h7d;
			7'h1c: ch = 8'h0a;
			7'h1e: ch = 8'h61;
			7'h1f: ch = 8'h73;
			7'h20: ch = 8'h64;
			7'h21: ch = 8'h66;
			7'h22: ch = 8'h67;
			7'h23: ch = 8'h68;
			7'h24: ch = 8'h6a;
			7'h25: ch = 8'h6b;
			7'h26: ch = 8'h6c;
			7'h27: ch = 8'h3a;
			7'h28: ch = 8'h22;
			7'h29: ch = 8'h7e;
			7'h2b: ch = 8'h7c;
			7'h2c: ch = 8'h7a;
			7'h2d: ch = 8'h78;
			7'h2e: ch = 8'h63;
			7'h2f: ch = 8'h76;
			7'h30: ch = 8'h62;
			7'h31: ch = 8'h6e;
			7'h32: ch = 8'h6d;
			7'h33: ch = 8'h3c;
			7'h34: ch = 8'h3e;
			7'h35: ch = 8'h3f;
			7'h37: ch = 8'h2a;
			7'h39: ch = 8'h20;
			7'h4a: ch = 8'h2d;
			7'h4e: ch = 8'h2b;
			7'h53: ch = 8'h7f;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

[rtl/kscd_cfg_regs.sv]
// kscd_cfg_regs: write-only register file holding the cursor and delete
// character codes. Depends on kscd_pkg.
`default_nettype none

module kscd_cfg_regs
	import kscd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] index,
	input  wire logic [7:0]           wdata,
	output kscd_cfg_t                 cfg
);

	kscd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_arrow  <= LEFT_ARROW_RST;
			cfg_q.right_arrow <= RIGHT_ARROW_RST;
			cfg_q.up_arrow    <= UP_ARROW_RST;
			cfg_q.down_arrow  <= DOWN_ARROW_RST;
			cfg_q.ext_delete  <= EXT_DELETE_RST;
		end else if (wr_en) begin
			// indexes past the last register are dropped
			unique case (index)
				REG_LEFT_ARROW:  cfg_q.left_arrow  <= wdata;
				REG_RIGHT_ARROW: cfg_q.right_arrow <= wdata;
				REG_UP_ARROW:    cfg_q.up_arrow    <= wdata;
				REG_DOWN_ARROW:  cfg_q.down_arrow  <= wdata;
				REG_EXT_DELETE:  cfg_q.ext_delete  <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/kscd_decode.sv]
// kscd_decode: combinational decode of one scan code byte against the
// current prefix, modifier and lock state. Depends on kscd_pkg.
`default_nettype none

module kscd_decode
	import kscd_pkg::*;
(
	input  wire logic [7:0] code,
	input  kscd_state_t     st,
	input  kscd_cfg_t       cfg,
	output kscd_state_t     st_next,
	output kscd_result_t    res
);

	logic       shift;
	logic       ctrl;
	logic       handle;
	logic       ext;
	logic       pause;
	logic [7:0] base;
	logic [7:0] tr_ch;
	event_t     tr_ev;

	assign shift = st.mods[MOD_LSHIFT] | st.mods[MOD_RSHIFT];
	assign ctrl  = st.mods[MOD_LCTRL]  | st.mods[MOD_RCTRL];

	// table translation for ordinary keys
	always_comb begin
		tr_ch = 8'h00;
		tr_ev = EV_NONE;
		base  = shift ? shift_map(code[6:0]) : plain_map(code[6:0]);
		if (code < SC_KEYPAD_BASE) begin
			if (base >= CH_LOWER_A && base <= CH_LOWER_Z) begin
				if (ctrl) begin
					if (base == CH_LOWER_C) begin
						tr_ev = EV_INTERRUPT;
					end else begin
						tr_ch = base - CTRL_OFFSET;
					end
				end else if (st.locks[LOCK_CAPS] ^ shift) begin
					tr_ch = base - CASE_OFFSET;
				end else begin
					tr_ch = base;
				end
			end else begin
				tr_ch = base;
			end
		end else if (code < TABLE_ENTRIES) begin
			// num lock flips the keypad between digits and editing keys
			if (!ext && (st.locks[LOCK_NUM] ^ shift)) begin
				tr_ch = plain_map(code[6:0]);
			end else begin
				tr_ch = shift_map(code[6:0]);
			end
		end
	end

	always_comb begin
		st_next        = st;
		res.char_code  = 8'h00;
		res.event_code = EV_NONE;
		handle         = 1'b0;
		ext            = 1'b0;
		pause          = 1'b0;

		unique case (st.prefix)
			PFX_IDLE: begin
				if (code == SC_E0) begin
					st_next.prefix = PFX_E0;
				end else if (code == SC_E1) begin
					st_next.prefix = PFX_E1;
				end else begin
					handle = 1'b1;
				end
			end
			PFX_E0: begin
				st_next.prefix = PFX_IDLE;
				handle         = 1'b1;
				ext            = 1'b1;
			end
			PFX_E1: begin
				st_next.prefix = (code == SC_CTRL || code == SC_CTRL_REL) ? PFX_E1_CTRL
				                                                          : PFX_IDLE;
			end
			PFX_E1_CTRL: begin
				st_next.prefix = PFX_IDLE;
				pause          = (code == SC_NUMLOCK);
			end
			default: st_next.prefix = PFX_IDLE;
		endcase

		if (pause) begin
			res.char_code = PAUSE_CHAR;
		end else if (handle) begin
			unique case (code)
				SC_ALT: begin
					if (ext) st_next.mods[MOD_RALT] = 1'b1;
					else     st_next.mods[MOD_LALT] = 1'b1;
				end
				SC_CTRL: begin
					if (ext) st_next.mods[MOD_RCTRL] = 1'b1;
					else     st_next.mods[MOD_LCTRL] = 1'b1;
				end
				SC_LSHIFT: st_next.mods[MOD_LSHIFT] = 1'b1;
				SC_RSHIFT: st_next.mods[MOD_RSHIFT] = 1'b1;
				SC_ALT_REL: begin
					if (ext) st_next.mods[MOD_RALT] = 1'b0;
					else     st_next.mods[MOD_LALT] = 1'b0;
				end
				SC_CTRL_REL: begin
					if (ext) st_next.mods[MOD_RCTRL] = 1'b0;
					else     st_next.mods[MOD_LCTRL] = 1'b0;
				end
				SC_LSHIFT_REL: st_next.mods[MOD_LSHIFT] = 1'b0;
				SC_RSHIFT_REL: st_next.mods[MOD_RSHIFT] = 1'b0;
				// a lock toggles only on a fresh press, not on repeats
				SC_NUMLOCK: begin
					if (!st.held[LOCK_NUM]) begin
						st_next.locks[LOCK_NUM] = ~st.locks[LOCK_NUM];
						st_next.held[LOCK_NUM]  = 1'b1;
					end
				end
				SC_CAPSLOCK: begin
					if (!st.held[LOCK_CAPS]) begin
						st_next.locks[LOCK_CAPS] = ~st.locks[LOCK_CAPS];
						st_next.held[LOCK_CAPS]  = 1'b1;
					end
				end
				SC_SCROLLLOCK: begin
					if (!st.held[LOCK_SCROLL]) begin
						st_next.locks[LOCK_SCROLL] = ~st.locks[LOCK_SCROLL];
						st_next.held[LOCK_SCROLL]  = 1'b1;
					end
				end
				SC_NUMLOCK_REL: st_next.held[LOCK_NUM]    = 1'b0;
				SC_CAPS_REL:    st_next.held[LOCK_CAPS]   = 1'b0;
				SC_SCROLL_REL:  st_next.held[LOCK_SCROLL] = 1'b0;
				SC_PAGE_UP:     res.event_code = EV_SCROLL_UP;
				SC_PAGE_DOWN:   res.event_code = EV_SCROLL_DOWN;
				SC_LEFT:        res.char_code  = cfg.left_arrow;
				SC_RIGHT:       res.char_code  = cfg.right_arrow;
				SC_UP:          res.char_code  = cfg.up_arrow;
				SC_DOWN:        res.char_code  = cfg.down_arrow;
				SC_DELETE: begin
					if (ext) begin
						res.char_code = cfg.ext_delete;
					end else begin
						res.char_code  = tr_ch;
						res.event_code = tr_ev;
					end
				end
				SC_W: begin
					if (ctrl) begin
						res.event_code = EV_DIAG_UP;
					end else begin
						res.char_code  = tr_ch;
						res.event_code = tr_ev;
					end
				end
				SC_S: begin
					if (ctrl) begin
						res.event_code = EV_DIAG_DOWN;
					end else begin
						res.char_code  = tr_ch;
						res.event_code = tr_ev;
					end
				end
				default: begin
					res.char_code  = tr_ch;
					res.event_code = tr_ev;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/keyboard_scan_code_decoder.sv]
// keyboard_scan_code_decoder: set-1 scan code to character decoder top level.
// Depends on kscd_pkg, kscd_cfg_regs and kscd_decode.
//
//   channel  handshake                payload
//   in       in_valid / in_ready      scan_code
//   out      out_valid / out_ready    char_valid, char_code, event_code, lock_status
//   cfg      cfg_wr_en                cfg_index, cfg_wdata
//
// one word per cycle sustained while out_ready stays high; a taken byte passes
// through the input register, then is decoded into the result register
// decoder state updates as a byte moves from the input register to the result
// register, so back-to-back bytes see each other's prefix and modifier changes
// a stalled output holds its word; the input register still takes one more word
// reset clears prefix, modifier and lock state and loads the register defaults
`default_nettype none

module keyboard_scan_code_decoder
	import kscd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           scan_code,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      char_valid,
	output logic [7:0]                char_code,
	output logic [2:0]                event_code,
	output logic [2:0]                lock_status,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_wdata
);

	kscd_cfg_t    cfg;
	kscd_state_t  state_q;
	kscd_state_t  state_next;
	kscd_result_t res;

	logic       valid_s1;
	logic [7:0] code_s1;
	logic       out_free;
	logic       adv_s1;

	logic       valid_s2;
	logic       char_valid_s2;
	logic [7:0] char_code_s2;
	logic [2:0] event_code_s2;
	logic [2:0] lock_status_s2;

	kscd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	kscd_decode u_decode (
		.code    (code_s1),
		.st      (state_q),
		.cfg     (cfg),
		.st_next (state_next),
		.res     (res)
	);

	assign out_free = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= scan_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.prefix <= PFX_IDLE;
			state_q.mods   <= '0;
			state_q.locks  <= '0;
			state_q.held   <= '0;
			valid_s2       <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_next;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			char_valid_s2  <= (res.char_code != 8'h00);
			char_code_s2   <= res.char_code;
			event_code_s2  <= res.event_code;
			lock_status_s2 <= state_next.locks;
		end
	end

	assign out_valid   = valid_s2;
	assign char_valid  = char_valid_s2;
	assign char_code   = char_code_s2;
	assign event_code  = event_code_s2;
	assign lock_status = lock_status_s2;

	// an empty result register must never block the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled while result register empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (event_code_s2 == EV_NONE || event_code_s2 == EV_SCROLL_UP ||
		              event_code_s2 == EV_SCROLL_DOWN || event_code_s2 == EV_DIAG_UP ||
		              event_code_s2 == EV_DIAG_DOWN || event_code_s2 == EV_INTERRUPT))
		else $error("event code out of range");

	// the pause sequence must leave the lock flags alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (state_q.prefix == PFX_E1 || state_q.prefix == PFX_E1_CTRL))
		|=> $stable(state_q.locks))
		else $error("lock flags changed inside an E1 sequence");

	// a held caps lock key cannot toggle caps lock again
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && state_q.held[LOCK_CAPS])
		|=> (state_q.locks[LOCK_CAPS] == $past(state_q.locks[LOCK_CAPS])))
		else $error("caps lock toggled while held");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (char_valid_s2 == (char_code_s2 != 8'h00)))
		else $error("char valid disagrees with char code");

endmodule

`default_nettype wire
